// ===== hdl/ddsg_pkg.sv =====
// Shared types and constants of the dual-tone DDS generator.
// Request codes, item structs and the work record passed from front to back.
// No dependencies.
package ddsg_pkg;

  localparam int unsigned DEF_TABLE_DEPTH = 256;
  localparam int unsigned DEF_RAMP_STEPS  = 1024;
  localparam int unsigned DEF_RATE_LOG2   = 17;
  localparam int unsigned QUEUE_DEPTH     = 4;

  localparam int SAMPLE_MID = 2047;
  localparam int SAMPLE_MAX = 4095;
  localparam int RAMP_SHIFT = 10;

  typedef enum logic [2:0] {
    REQ_TICK        = 3'd0,
    REQ_START_BURST = 3'd1,
    REQ_END_BURST   = 3'd2,
    REQ_START_TEST  = 3'd3,
    REQ_STOP        = 3'd4
  } req_e;

  // Values of the gen_mode result field.
  localparam logic [1:0] GM_IDLE = 2'd0;
  localparam logic [1:0] GM_TONE = 2'd1;
  localparam logic [1:0] GM_DUAL = 2'd2;
  localparam logic [1:0] GM_FADE = 2'd3;

  typedef enum logic [1:0] {
    KIND_OFF  = 2'd0,
    KIND_TEST = 2'd1,
    KIND_DUAL = 2'd2
  } work_kind_e;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [15:0] freq_a;
    logic [15:0] freq_b;
  } in_item_t;

  typedef struct packed {
    logic [11:0] dac_sample;
    logic [1:0]  gen_mode;
  } out_item_t;

  typedef struct packed {
    work_kind_e  kind;
    logic [1:0]  gen_mode;
    logic [31:0] phase_low;
    logic [31:0] phase_high;
  } work_t;

endpackage

// ===== hdl/ddsg_fifo.sv =====
// Small generic first-in first-out queue with push/full and pop/empty sides.
// Used between front and back and as the result queue. No dependencies.
module ddsg_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             wr, rd;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign wr      = push_i && !full_o;
  assign rd      = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (wr) begin
      wptr_d = (wptr_q == PtrW'(DEPTH - 1)) ? '0 : wptr_q + PtrW'(1);
    end
    if (rd) begin
      rptr_d = (rptr_q == PtrW'(DEPTH - 1)) ? '0 : rptr_q + PtrW'(1);
    end
    case ({wr, rd})
      2'b10:   cnt_d = cnt_q + CntW'(1);
      2'b01:   cnt_d = cnt_q - CntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

// ===== hdl/ddsg_front.sv =====
// Front end: accepts requests, applies commands to the mode, ramp and tone
// state, advances the phase accumulators and queues one work record per tick.
// Depends on ddsg_pkg.
module ddsg_front #(
  parameter int unsigned RAMP_STEPS = ddsg_pkg::DEF_RAMP_STEPS,
  parameter int unsigned RATE_LOG2  = ddsg_pkg::DEF_RATE_LOG2,
  parameter int unsigned RAMP_W     = $clog2(RAMP_STEPS + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  ddsg_pkg::in_item_t item_i,
  input  logic               work_full_i,
  output logic               work_push_o,
  output ddsg_pkg::work_t    work_o,
  output logic [RAMP_W-1:0]  work_ramp_o
);
  import ddsg_pkg::*;

  localparam int unsigned IncShift = 32 - RATE_LOG2;
  localparam logic [RAMP_W-1:0] RampMax = RAMP_W'(RAMP_STEPS);

  typedef enum logic [3:0] {
    ST_OFF    = 4'b0001,
    ST_TEST   = 4'b0010,
    ST_BURST  = 4'b0100,
    ST_ENDING = 4'b1000
  } mode_e;

  function automatic logic [1:0] mode_code(input mode_e m);
    case (m)
      ST_TEST:   return GM_TONE;
      ST_BURST:  return GM_DUAL;
      ST_ENDING: return GM_FADE;
      default:   return GM_IDLE;
    endcase
  endfunction

  mode_e             mode_q, mode_d;
  logic [RAMP_W-1:0] ramp_q, ramp_d;
  logic [31:0]       phase_lo_q, phase_lo_d, phase_hi_q, phase_hi_d;
  logic [15:0]       tone_lo_q, tone_lo_d, tone_hi_q, tone_hi_d;
  logic [31:0]       inc_lo, inc_hi;
  logic              accept;
  work_kind_e        kind;

  assign accept = push_i && !work_full_i;
  assign inc_lo = 32'(tone_lo_q) << IncShift;
  assign inc_hi = 32'(tone_hi_q) << IncShift;

  always_comb begin
    mode_d      = mode_q;
    ramp_d      = ramp_q;
    phase_lo_d  = phase_lo_q;
    phase_hi_d  = phase_hi_q;
    tone_lo_d   = tone_lo_q;
    tone_hi_d   = tone_hi_q;
    work_push_o = 1'b0;
    kind        = KIND_OFF;
    if (accept) begin
      case (req_e'(item_i.req_type))
        REQ_START_BURST: begin
          tone_lo_d = item_i.freq_a;
          tone_hi_d = item_i.freq_b;
          ramp_d    = '0;
          mode_d    = ST_BURST;
        end
        REQ_END_BURST: begin
          mode_d = ST_ENDING;
        end
        REQ_START_TEST: begin
          tone_lo_d = item_i.freq_a;
          tone_hi_d = '0;
          mode_d    = ST_TEST;
        end
        REQ_STOP: begin
          tone_lo_d = '0;
          tone_hi_d = '0;
          mode_d    = ST_OFF;
        end
        REQ_TICK: begin
          work_push_o = 1'b1;
          case (mode_q)
            ST_TEST: begin
              phase_lo_d = phase_lo_q + inc_lo;
              kind       = KIND_TEST;
            end
            ST_BURST: begin
              if (ramp_q < RampMax) begin
                ramp_d = ramp_q + RAMP_W'(1);
              end
              phase_lo_d = phase_lo_q + inc_lo;
              phase_hi_d = phase_hi_q + inc_hi;
              kind       = KIND_DUAL;
            end
            ST_ENDING: begin
              // The tick that reaches zero still advances both phases.
              if (ramp_q != '0) begin
                ramp_d = ramp_q - RAMP_W'(1);
              end else begin
                mode_d = ST_OFF;
              end
              phase_lo_d = phase_lo_q + inc_lo;
              phase_hi_d = phase_hi_q + inc_hi;
              kind       = KIND_DUAL;
            end
            default: kind = KIND_OFF;
          endcase
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    work_o.kind       = kind;
    work_o.gen_mode   = mode_code(mode_d);
    work_o.phase_low  = phase_lo_d;
    work_o.phase_high = phase_hi_d;
    work_ramp_o       = ramp_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= ST_OFF;
      ramp_q     <= '0;
      phase_lo_q <= '0;
      phase_hi_q <= '0;
      tone_lo_q  <= '0;
      tone_hi_q  <= '0;
    end else begin
      mode_q     <= mode_d;
      ramp_q     <= ramp_d;
      phase_lo_q <= phase_lo_d;
      phase_hi_q <= phase_hi_d;
      tone_lo_q  <= tone_lo_d;
      tone_hi_q  <= tone_hi_d;
    end
  end

endmodule

// ===== hdl/ddsg_back.sv =====
// Back end: turns queued work records into DAC samples. Stage one maps the
// phases to table indexes, stage two reads the cosine table and forms the
// sum, the last step scales by the ramp. Depends on ddsg_pkg.
module ddsg_back #(
  parameter int unsigned TABLE_DEPTH = ddsg_pkg::DEF_TABLE_DEPTH,
  parameter int unsigned RAMP_W      = $clog2(ddsg_pkg::DEF_RAMP_STEPS + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                work_valid_i,
  input  ddsg_pkg::work_t     work_i,
  input  logic [RAMP_W-1:0]   work_ramp_i,
  output logic                work_pop_o,
  input  logic                out_full_i,
  output logic                out_push_o,
  output ddsg_pkg::out_item_t out_item_o
);
  import ddsg_pkg::*;

  localparam int unsigned IdxW  = $clog2(TABLE_DEPTH);
  localparam int unsigned DepW  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned ProdW = 32 + DepW;
  localparam int unsigned ScW   = RAMP_W + 12;
  localparam logic [63:0] HalfPiQ31 = 64'd3373259426;
  localparam logic [63:0] OneQ31    = 64'd2147483648;

  // cos(pi/2 * r / TABLE_DEPTH) in Q31 by a thirteen-term series.
  function automatic logic signed [63:0] quarter_cos(input logic [63:0] r);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] acc;
    x    = (HalfPiQ31 * r) / 64'(TABLE_DEPTH);
    x2   = (x * x) >> 31;
    term = OneQ31;
    acc  = $signed(OneQ31);
    for (int n = 1; n <= 12; n++) begin
      term = ((term * x2) >> 31) / 64'((2 * n - 1) * (2 * n));
      if ((n % 2) == 1) begin
        acc = acc - $signed(term);
      end else begin
        acc = acc + $signed(term);
      end
    end
    return acc;
  endfunction

  function automatic logic signed [11:0] rom_entry(input int unsigned i);
    int unsigned        q;
    int unsigned        quad;
    int unsigned        rem;
    logic signed [63:0] c;
    logic signed [63:0] v;
    logic [63:0]        mag;
    q    = 4 * i;
    quad = q / TABLE_DEPTH;
    rem  = q % TABLE_DEPTH;
    case (quad)
      0:       c = quarter_cos(64'(rem));
      1:       c = -quarter_cos(64'(TABLE_DEPTH - rem));
      2:       c = -quarter_cos(64'(rem));
      default: c = quarter_cos(64'(TABLE_DEPTH - rem));
    endcase
    v   = 64'sd2047 * c;
    mag = $unsigned((v < 0) ? -v : v) >> 31;
    if (mag > 64'd2047) begin
      mag = 64'd2047;
    end
    return (v < 0) ? -$signed(12'(mag)) : $signed(12'(mag));
  endfunction

  logic signed [11:0] rom_tbl [TABLE_DEPTH];

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_rom
    assign rom_tbl[g] = rom_entry(g);
  end

  logic              s1_valid_q, s2_valid_q;
  work_kind_e        s1_kind_q, s2_kind_q;
  logic [1:0]        s1_mode_q, s2_mode_q;
  logic [RAMP_W-1:0] s1_ramp_q, s2_ramp_q;
  logic [IdxW-1:0]   s1_idx_lo_q, s1_idx_hi_q;
  logic [11:0]       s2_sum_q;
  logic              s1_adv, s2_adv;
  logic [ProdW-1:0]  prod_lo, prod_hi;
  logic signed [11:0] cos_lo, cos_hi;
  logic signed [13:0] dual_sum, test_sum;
  logic [11:0]       sum_d;
  logic [ScW-1:0]    scaled_prod;
  logic [RAMP_W+1:0] scaled;
  logic [11:0]       sample;

  // A stage moves on when the one after it is empty or moving too.
  assign s2_adv     = !s2_valid_q || !out_full_i;
  assign s1_adv     = !s1_valid_q || s2_adv;
  assign work_pop_o = work_valid_i && s1_adv;
  assign out_push_o = s2_valid_q && !out_full_i;

  assign prod_lo = ProdW'(work_i.phase_low) * ProdW'(TABLE_DEPTH);
  assign prod_hi = ProdW'(work_i.phase_high) * ProdW'(TABLE_DEPTH);

  always_comb begin
    cos_lo   = rom_tbl[s1_idx_lo_q];
    cos_hi   = rom_tbl[s1_idx_hi_q];
    dual_sum = 14'(SAMPLE_MID) + 14'(cos_lo >>> 1) + 14'(cos_hi >>> 1);
    test_sum = 14'(SAMPLE_MID) + 14'(cos_lo);
    case (s1_kind_q)
      KIND_TEST: sum_d = test_sum[11:0];
      KIND_DUAL: sum_d = dual_sum[13] ? '0 : dual_sum[11:0];
      default:   sum_d = '0;
    endcase
  end

  always_comb begin
    scaled_prod = ScW'(s2_ramp_q) * ScW'(s2_sum_q);
    scaled      = scaled_prod[ScW-1:RAMP_SHIFT];
    if (s2_kind_q == KIND_DUAL) begin
      sample = (32'(scaled) > 32'(SAMPLE_MAX)) ? 12'(SAMPLE_MAX) : 12'(scaled);
    end else begin
      sample = s2_sum_q;
    end
    out_item_o.dac_sample = sample;
    out_item_o.gen_mode   = s2_mode_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_valid_q <= work_pop_o;
      end
      if (s2_adv) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s1_kind_q   <= work_i.kind;
      s1_mode_q   <= work_i.gen_mode;
      s1_ramp_q   <= work_ramp_i;
      s1_idx_lo_q <= prod_lo[32 +: IdxW];
      s1_idx_hi_q <= prod_hi[32 +: IdxW];
    end
    if (s2_adv) begin
      s2_kind_q <= s1_kind_q;
      s2_mode_q <= s1_mode_q;
      s2_ramp_q <= s1_ramp_q;
      s2_sum_q  <= sum_d;
    end
  end

endmodule

// ===== hdl/dual_tone_dds_generator.sv =====
// Dual-tone DDS generator with amplitude ramp.
// A command request gives no result. A tick request gives one sample, which
// passes the work queue, the back-end stages and the result queue. Throughput
// is one request per cycle while the work queue is not full; a work queue and
// a result queue let each side stall on its own. Reset is asynchronous and
// active low; it clears mode, ramp, tones, phases and both queues at once.
module dual_tone_dds_generator #(
  parameter int unsigned TABLE_DEPTH = ddsg_pkg::DEF_TABLE_DEPTH,
  parameter int unsigned RAMP_STEPS  = ddsg_pkg::DEF_RAMP_STEPS,
  parameter int unsigned RATE_LOG2   = ddsg_pkg::DEF_RATE_LOG2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  ddsg_pkg::in_item_t  in_item_i,
  output logic                empty,
  input  logic                pop,
  output ddsg_pkg::out_item_t out_item_o
);
  import ddsg_pkg::*;

  localparam int unsigned RampW = $clog2(RAMP_STEPS + 1);
  localparam int unsigned WorkW = $bits(work_t) + RampW;
  localparam int unsigned OutW  = $bits(out_item_t);

  logic             fr_push, bk_pop, mid_empty, mid_full;
  work_t            fr_work, bk_work;
  logic [RampW-1:0] fr_ramp, bk_ramp;
  logic [WorkW-1:0] mid_wdata, mid_rdata;
  logic             bk_push, out_full;
  out_item_t        bk_item;
  logic [OutW-1:0]  out_rdata;

  assign full = mid_full;

  ddsg_front #(
    .RAMP_STEPS (RAMP_STEPS),
    .RATE_LOG2  (RATE_LOG2),
    .RAMP_W     (RampW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .item_i      (in_item_i),
    .work_full_i (mid_full),
    .work_push_o (fr_push),
    .work_o      (fr_work),
    .work_ramp_o (fr_ramp)
  );

  assign mid_wdata = {fr_work, fr_ramp};
  assign bk_work   = work_t'(mid_rdata[WorkW-1:RampW]);
  assign bk_ramp   = mid_rdata[RampW-1:0];

  ddsg_fifo #(
    .WIDTH (WorkW),
    .DEPTH (QUEUE_DEPTH)
  ) u_work_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fr_push),
    .data_i  (mid_wdata),
    .full_o  (mid_full),
    .pop_i   (bk_pop),
    .data_o  (mid_rdata),
    .empty_o (mid_empty)
  );

  ddsg_back #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .RAMP_W      (RampW)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .work_valid_i (!mid_empty),
    .work_i       (bk_work),
    .work_ramp_i  (bk_ramp),
    .work_pop_o   (bk_pop),
    .out_full_i   (out_full),
    .out_push_o   (bk_push),
    .out_item_o   (bk_item)
  );

  ddsg_fifo #(
    .WIDTH (OutW),
    .DEPTH (QUEUE_DEPTH)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (bk_push),
    .data_i  (bk_item),
    .full_o  (out_full),
    .pop_i   (pop),
    .data_o  (out_rdata),
    .empty_o (empty)
  );

  assign out_item_o = out_item_t'(out_rdata);

endmodule

// ===== sim/tb.sv =====
// Testbench for the dual-tone DDS generator: directed and random request streams
// checked against a built-in model of the tone, ramp and mode behavior.
// Depends on ddsg_pkg and dual_tone_dds_generator.
`timescale 1ns / 1ps

module tb;
  import ddsg_pkg::*;

  localparam int unsigned TABLE_SIZE     = DEF_TABLE_DEPTH;
  localparam int unsigned RANDOM_ITEMS   = 600;
  localparam int unsigned RAMP_TICKS     = DEF_RAMP_STEPS + 6;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned SETTLE_CYCLES  = 10;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned MAX_REPORTS    = 40;

  localparam logic [2:0] REQ_UNUSED_MIN = 3'd5;
  localparam logic [2:0] REQ_UNUSED_MAX = 3'd7;

  localparam longint unsigned HALF_PI_Q31 = 64'd3373259426;
  localparam longint unsigned ONE_Q31     = 64'd2147483648;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      push = 1'b0;
  logic      pop = 1'b0;
  logic      full;
  logic      empty;
  in_item_t  req_item = '0;
  out_item_t sample_item;

  dual_tone_dds_generator u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (req_item),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (sample_item)
  );

  always #5 clk_i = ~clk_i;

  // Generator model state.
  int          cos_table [TABLE_SIZE];
  logic [1:0]  model_mode = GM_IDLE;
  int unsigned model_ramp = 0;
  logic [31:0] model_phase_low = '0;
  logic [31:0] model_phase_high = '0;
  logic [15:0] model_freq_low = '0;
  logic [15:0] model_freq_high = '0;

  out_item_t   expected_samples [$];
  int unsigned mismatch_count = 0;
  int unsigned items_sent = 0;
  int unsigned quiet_cycles = 0;
  bit          sender_gaps = 1'b1;
  bit          receiver_gaps = 1'b1;
  bit          hold_request = 1'b0;

  // cos(pi/2 * r / TABLE_SIZE) in Q31 by a truncated Taylor series.
  function automatic longint quarter_cos(int unsigned r);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          acc;
    x = (HALF_PI_Q31 * 64'(r)) / 64'(TABLE_SIZE);
    x2 = (x * x) >> 31;
    term = ONE_Q31;
    acc = longint'(ONE_Q31);
    for (int unsigned n = 1; n <= 12; n++) begin
      term = ((term * x2) >> 31) / 64'((2 * n - 1) * (2 * n));
      if (n % 2 == 1) acc -= longint'(term);
      else acc += longint'(term);
    end
    return acc;
  endfunction

  function automatic int cos_entry(int unsigned i);
    int unsigned     quad;
    int unsigned     rem;
    longint          c;
    longint          v;
    longint unsigned mag;
    quad = (4 * i) / TABLE_SIZE;
    rem = (4 * i) % TABLE_SIZE;
    case (quad)
      0: c = quarter_cos(rem);
      1: c = -quarter_cos(TABLE_SIZE - rem);
      2: c = -quarter_cos(rem);
      default: c = quarter_cos(TABLE_SIZE - rem);
    endcase
    v = SAMPLE_MID * c;
    mag = $unsigned(v < 0 ? -v : v) >> 31;
    if (mag > SAMPLE_MID) mag = SAMPLE_MID;
    return v < 0 ? -int'(mag) : int'(mag);
  endfunction

  function automatic logic [31:0] phase_step(logic [15:0] freq);
    return 32'(freq) << (32 - DEF_RATE_LOG2);
  endfunction

  function automatic int tone_value(logic [31:0] phase);
    return cos_table[int'((64'(phase) * TABLE_SIZE) >> 32)];
  endfunction

  // Applies one accepted request to the model and queues the sample a tick gives.
  task automatic advance_generator(input in_item_t req);
    out_item_t       want;
    int              total;
    longint unsigned scaled;
    case (req.req_type)
      REQ_START_BURST: begin
        model_freq_low = req.freq_a;
        model_freq_high = req.freq_b;
        model_ramp = 0;
        model_mode = GM_DUAL;
      end
      REQ_END_BURST: model_mode = GM_FADE;
      REQ_START_TEST: begin
        model_freq_low = req.freq_a;
        model_freq_high = '0;
        model_mode = GM_TONE;
      end
      REQ_STOP: begin
        model_freq_low = '0;
        model_freq_high = '0;
        model_mode = GM_IDLE;
      end
      REQ_TICK: begin
        want.dac_sample = '0;
        if (model_mode == GM_TONE) begin
          model_phase_low += phase_step(model_freq_low);
          want.dac_sample = 12'(SAMPLE_MID + tone_value(model_phase_low));
        end else if (model_mode != GM_IDLE) begin
          if (model_mode == GM_DUAL) begin
            if (model_ramp < DEF_RAMP_STEPS) model_ramp++;
          end else if (model_ramp > 0) begin
            model_ramp--;
          end else begin
            model_mode = GM_IDLE;
          end
          model_phase_low += phase_step(model_freq_low);
          model_phase_high += phase_step(model_freq_high);
          // Each tone is halved with rounding toward minus infinity.
          total = SAMPLE_MID + (tone_value(model_phase_low) >>> 1)
                  + (tone_value(model_phase_high) >>> 1);
          if (total < 0) total = 0;
          scaled = (64'(model_ramp) * 64'(total)) >> RAMP_SHIFT;
          want.dac_sample = (scaled > SAMPLE_MAX) ? 12'(SAMPLE_MAX) : 12'(scaled);
        end
        want.gen_mode = model_mode;
        expected_samples.push_back(want);
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_REPORTS) $display("ERROR at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic check_sample(input out_item_t got);
    out_item_t want;
    if (expected_samples.size() == 0) begin
      report_mismatch($sformatf("sample %0d mode %0d with none expected",
                                got.dac_sample, got.gen_mode));
      return;
    end
    want = expected_samples.pop_front();
    if (got.dac_sample !== want.dac_sample)
      report_mismatch($sformatf("dac_sample %0d, expected %0d", got.dac_sample,
                                want.dac_sample));
    if (got.gen_mode !== want.gen_mode)
      report_mismatch($sformatf("gen_mode %0d, expected %0d", got.gen_mode,
                                want.gen_mode));
  endtask

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned idle_gap();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic in_item_t make_request(logic [2:0] kind, logic [15:0] fa,
                                            logic [15:0] fb);
    in_item_t req;
    req.req_type = kind;
    req.freq_a = fa;
    req.freq_b = fb;
    return req;
  endfunction

  function automatic logic [15:0] random_freq();
    int unsigned pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    if (pick < 4) return 16'($urandom_range(1, 4000));
    return 16'($urandom());
  endfunction

  // Offers one request and returns right after the edge that accepts it.
  // Push stays high between back-to-back requests.
  task automatic send_request(input in_item_t req);
    int unsigned gap;
    gap = sender_gaps ? idle_gap() : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    req_item <= req;
    do @(posedge clk_i); while (full);
    advance_generator(req);
    items_sent++;
  endtask

  task automatic send_ticks(input int unsigned count);
    repeat (count) send_request(make_request(REQ_TICK, 16'($urandom()), 16'($urandom())));
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic test_off_tick();
    send_ticks(1);
  endtask

  // Equal tones at a quarter turn per tick meet at the cosine minimum on the
  // second tick, which drives the sum below zero. The short ramp then lets the
  // ending phase run down to zero and switch off.
  task automatic test_burst_clamp();
    send_request(make_request(REQ_START_BURST, 16'h8000, 16'h8000));
    send_ticks(4);
    send_request(make_request(REQ_END_BURST, '0, '0));
    send_ticks(5);
  endtask

  task automatic test_field_extremes();
    send_request(make_request(REQ_START_TEST, '1, '1));
    send_ticks(1);
    send_request(make_request(REQ_START_TEST, '0, '0));
    send_ticks(1);
    send_request(make_request(REQ_START_BURST, '0, '1));
    send_ticks(1);
    send_request(make_request(REQ_STOP, '1, '0));
    send_request(make_request(REQ_END_BURST, '1, '1));
    send_ticks(1);
    for (int unsigned code = REQ_UNUSED_MIN; code <= REQ_UNUSED_MAX; code++)
      send_request(make_request(3'(code), '1, '1));
    send_ticks(1);
  endtask

  // Full-rate burst long enough to reach the top of the ramp.
  task automatic test_ramp_limit();
    wait_drained();
    sender_gaps = 1'b0;
    receiver_gaps = 1'b0;
    send_request(make_request(REQ_START_BURST, random_freq(), random_freq()));
    send_ticks(RAMP_TICKS);
    send_request(make_request(REQ_END_BURST, '0, '0));
    send_ticks(3);
    send_request(make_request(REQ_STOP, '0, '0));
    sender_gaps = 1'b1;
    receiver_gaps = 1'b1;
  endtask

  // The receiver holds off while ticks keep coming, so the block fills and
  // pushes back on the request side.
  task automatic test_backpressure();
    wait_drained();
    sender_gaps = 1'b0;
    send_request(make_request(REQ_START_TEST, random_freq(), '0));
    hold_request = 1'b1;
    send_ticks(40);
    sender_gaps = 1'b1;
    wait_drained();
  endtask

  task automatic test_random_traffic();
    int unsigned first;
    int unsigned pick;
    first = items_sent;
    while (items_sent - first < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        send_request(make_request(REQ_START_BURST, random_freq(), random_freq()));
        send_ticks($urandom_range(1, 40));
        if ($urandom_range(0, 7) != 0) begin
          send_request(make_request(REQ_END_BURST, 16'($urandom()), 16'($urandom())));
          send_ticks($urandom_range(0, 45));
        end
      end else if (pick < 70) begin
        send_request(make_request(REQ_START_TEST, random_freq(), 16'($urandom())));
        send_ticks($urandom_range(1, 20));
      end else if (pick < 80) begin
        send_request(make_request(REQ_STOP, 16'($urandom()), 16'($urandom())));
        send_ticks($urandom_range(1, 6));
      end else begin
        repeat ($urandom_range(1, 8))
          send_request(make_request(3'($urandom_range(0, REQ_UNUSED_MAX)),
                                    16'($urandom()), 16'($urandom())));
      end
      if ($urandom_range(0, 19) == 0) wait_drained();
    end
  endtask

  // Result side: checks each accepted sample, then decides on pop for the
  // next cycle, including the long hold-off.
  initial begin : receiver
    int unsigned pop_gap;
    pop_gap = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && pop && !empty) check_sample(sample_item);
      if (hold_request) begin
        hold_request = 1'b0;
        pop_gap = HOLD_CYCLES;
      end
      if (pop_gap > 0) begin
        pop <= 1'b0;
        pop_gap--;
      end else begin
        pop <= 1'b1;
        pop_gap = receiver_gaps ? idle_gap() : 0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("Timeout: no request or sample moved for %0d cycles", WATCHDOG_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    for (int unsigned i = 0; i < TABLE_SIZE; i++) cos_table[i] = cos_entry(i);
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_off_tick();
    test_burst_clamp();
    test_field_extremes();
    test_ramp_limit();
    test_backpressure();
    test_random_traffic();
    wait_drained();
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
